// ===== hw/rtl/mimo_gauss_seidel_detector_assert.svh =====
// assertion macros for the mimo gauss-seidel detector
`ifndef MIMO_GAUSS_SEIDEL_DETECTOR_ASSERT_SVH
`define MIMO_GAUSS_SEIDEL_DETECTOR_ASSERT_SVH

// condition implies consequence in the same cycle
`define MGSD_ASSERT_NOW(label, clk, rstn, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
        else $error("assertion failed");

// condition implies consequence in the next cycle
`define MGSD_ASSERT_NEXT(label, clk, rstn, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/mgsd_pkg.sv =====
// shared types and constants of the gauss-seidel detector
`timescale 1ns / 1ps
package mgsd_pkg;

    localparam int IDX_W       = 4;
    localparam int SMP_W       = 16;
    localparam int EST_W       = 18;
    localparam int FRAC_BITS   = 12;
    localparam int Q_BITS      = 19;
    localparam int RESULT_LIMIT = 4;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 6;

    localparam logic [EST_W-1:0] EST_MAX = 18'h1FFFF;
    localparam logic [EST_W-1:0] EST_MIN = 18'h20000;

    localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_TX   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_RX   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SWEEP_COUNT = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLEAR, ST_ROW, ST_RMUL, ST_RSUB, ST_NMUL, ST_NACC,
        ST_DINIT, ST_DSTEP, ST_DWRITE, ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_CLEAR, OP_ROW, OP_RMUL, OP_RSUB, OP_NMUL, OP_NACC,
        OP_DINIT, OP_DSTEP, OP_DWRITE
    } op_t;

    // command from controller to datapath
    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             self;
        logic             first_row;
    } cmd_t;

    // estimate read back for the result stage
    typedef struct packed {
        logic signed [EST_W-1:0] est_re;
        logic signed [EST_W-1:0] est_im;
    } status_t;

    // store write from an accepted input request
    typedef struct packed {
        logic                    we;
        logic                    mode;
        logic [1:0]              rx;
        logic [1:0]              tx;
        logic signed [SMP_W-1:0] re;
        logic signed [SMP_W-1:0] im;
    } load_t;

endpackage

// ===== hw/rtl/mgsd_datapath.sv =====
// stores, shared complex multiply-accumulate and two-lane serial divider
`timescale 1ns / 1ps
module mgsd_datapath #(
    parameter int MAX_TX = 4,
    parameter int MAX_RX = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  mgsd_pkg::load_t  load,
    input  mgsd_pkg::cmd_t   cmd,
    output mgsd_pkg::status_t status
);
    localparam int TX_AW = (MAX_TX > 1) ? $clog2(MAX_TX) : 1;
    localparam int RX_AW = (MAX_RX > 1) ? $clog2(MAX_RX) : 1;
    localparam int PR_W  = 35;
    localparam int RES_W = 37 + TX_AW;
    localparam int NP_W  = RES_W + 17;
    localparam int NUM_W = NP_W + RX_AW + 1;
    localparam int PP_W  = 34;
    localparam int POW_W = PP_W + RX_AW + 1;
    localparam int DV_W  = NUM_W + 2;
    localparam int QW    = mgsd_pkg::Q_BITS;
    localparam int EW    = mgsd_pkg::EST_W;
    localparam int SW    = mgsd_pkg::SMP_W;

    logic signed [SW-1:0] ch_re [MAX_RX][MAX_TX];
    logic signed [SW-1:0] ch_im [MAX_RX][MAX_TX];
    logic signed [SW-1:0] smp_re [MAX_RX];
    logic signed [SW-1:0] smp_im [MAX_RX];
    logic signed [EW-1:0] est_re_reg [MAX_TX];
    logic signed [EW-1:0] est_im_reg [MAX_TX];

    logic signed [PR_W-1:0]  p_re_reg, p_im_reg;
    logic signed [RES_W-1:0] res_re_reg, res_im_reg;
    logic signed [NP_W-1:0]  np_re_reg, np_im_reg;
    logic signed [PP_W-1:0]  pp_reg;
    logic signed [NUM_W-1:0] num_re_reg, num_im_reg;
    logic signed [POW_W-1:0] pow_reg;
    logic [DV_W-1:0] rem_re_reg, rem_im_reg, dsh_reg;
    logic [QW-1:0]   q_re_reg, q_im_reg;
    logic            ovf_re_reg, ovf_im_reg, neg_re_reg, neg_im_reg;

    logic [RX_AW-1:0] row_a;
    logic [TX_AW-1:0] col_a;
    logic signed [SW-1:0] h_re, h_im, y_re, y_im;
    logic signed [EW-1:0] m_re, m_im;
    logic [NUM_W-1:0] mag_re, mag_im;
    logic [DV_W-1:0]  d_re, d_im, d2, d2_top;
    logic [EW-1:0]    wr_re, wr_im;

    assign row_a = cmd.row[RX_AW-1:0];
    assign col_a = cmd.col[TX_AW-1:0];
    assign h_re  = ch_re[row_a][col_a];
    assign h_im  = ch_im[row_a][col_a];
    assign y_re  = smp_re[row_a];
    assign y_im  = smp_im[row_a];
    assign m_re  = est_re_reg[col_a];
    assign m_im  = est_im_reg[col_a];
    assign status.est_re = m_re;
    assign status.est_im = m_im;

    // store writes from input requests
    always_ff @(posedge aclk) begin
        if (load.we) begin
            if (!load.mode) begin
                if (int'(load.rx) < MAX_RX && int'(load.tx) < MAX_TX) begin
                    ch_re[RX_AW'(load.rx)][TX_AW'(load.tx)] <= load.re;
                    ch_im[RX_AW'(load.rx)][TX_AW'(load.tx)] <= load.im;
                end
            end else if (int'(load.rx) < MAX_RX) begin
                smp_re[RX_AW'(load.rx)] <= load.re;
                smp_im[RX_AW'(load.rx)] <= load.im;
            end
        end
    end

    // divider operand forming
    always_comb begin
        mag_re = num_re_reg[NUM_W-1] ? NUM_W'(-num_re_reg) : NUM_W'(num_re_reg);
        mag_im = num_im_reg[NUM_W-1] ? NUM_W'(-num_im_reg) : NUM_W'(num_im_reg);
        d2     = DV_W'({pow_reg, 1'b0});
        d_re   = DV_W'({mag_re, 1'b0}) + DV_W'(pow_reg);
        d_im   = DV_W'({mag_im, 1'b0}) + DV_W'(pow_reg);
        d2_top = d2 << QW;
    end

    // rounding result saturated to the estimate range
    always_comb begin
        if (!neg_re_reg)
            wr_re = (ovf_re_reg || q_re_reg > QW'(mgsd_pkg::EST_MAX))
                    ? mgsd_pkg::EST_MAX : EW'(q_re_reg);
        else
            wr_re = (ovf_re_reg || q_re_reg > QW'(mgsd_pkg::EST_MIN))
                    ? mgsd_pkg::EST_MIN : EW'(-q_re_reg);
        if (!neg_im_reg)
            wr_im = (ovf_im_reg || q_im_reg > QW'(mgsd_pkg::EST_MAX))
                    ? mgsd_pkg::EST_MAX : EW'(q_im_reg);
        else
            wr_im = (ovf_im_reg || q_im_reg > QW'(mgsd_pkg::EST_MIN))
                    ? mgsd_pkg::EST_MIN : EW'(-q_im_reg);
    end

    // estimate store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int t = 0; t < MAX_TX; t++) begin
                est_re_reg[t] <= '0;
                est_im_reg[t] <= '0;
            end
        end else begin
            case (cmd.op)
                mgsd_pkg::OP_CLEAR: begin
                    for (int t = 0; t < MAX_TX; t++) begin
                        est_re_reg[t] <= '0;
                        est_im_reg[t] <= '0;
                    end
                end
                mgsd_pkg::OP_DWRITE: begin
                    if (pow_reg != '0) begin
                        est_re_reg[col_a] <= wr_re;
                        est_im_reg[col_a] <= wr_im;
                    end
                end
                default: ;
            endcase
        end
    end

    // multiply-accumulate and divider registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            mgsd_pkg::OP_ROW: begin
                res_re_reg <= RES_W'($signed({y_re, 12'b0}));
                res_im_reg <= RES_W'($signed({y_im, 12'b0}));
                if (cmd.first_row) begin
                    num_re_reg <= '0;
                    num_im_reg <= '0;
                    pow_reg    <= '0;
                end
            end
            mgsd_pkg::OP_RMUL: begin
                p_re_reg <= PR_W'(h_re * m_re) - PR_W'(h_im * m_im);
                p_im_reg <= PR_W'(h_re * m_im) + PR_W'(h_im * m_re);
            end
            mgsd_pkg::OP_RSUB: begin
                if (!cmd.self) begin
                    res_re_reg <= res_re_reg - RES_W'(p_re_reg);
                    res_im_reg <= res_im_reg - RES_W'(p_im_reg);
                end
            end
            mgsd_pkg::OP_NMUL: begin
                np_re_reg <= NP_W'(h_re * res_re_reg) + NP_W'(h_im * res_im_reg);
                np_im_reg <= NP_W'(h_re * res_im_reg) - NP_W'(h_im * res_re_reg);
                pp_reg    <= PP_W'(h_re * h_re) + PP_W'(h_im * h_im);
            end
            mgsd_pkg::OP_NACC: begin
                num_re_reg <= num_re_reg + NUM_W'(np_re_reg);
                num_im_reg <= num_im_reg + NUM_W'(np_im_reg);
                pow_reg    <= pow_reg + POW_W'(pp_reg);
            end
            mgsd_pkg::OP_DINIT: begin
                rem_re_reg <= d_re;
                rem_im_reg <= d_im;
                ovf_re_reg <= d_re >= d2_top;
                ovf_im_reg <= d_im >= d2_top;
                neg_re_reg <= num_re_reg[NUM_W-1];
                neg_im_reg <= num_im_reg[NUM_W-1];
                dsh_reg    <= d2 << (QW - 1);
                q_re_reg   <= '0;
                q_im_reg   <= '0;
            end
            mgsd_pkg::OP_DSTEP: begin
                if (rem_re_reg >= dsh_reg) begin
                    rem_re_reg <= rem_re_reg - dsh_reg;
                    q_re_reg   <= {q_re_reg[QW-2:0], 1'b1};
                end else begin
                    q_re_reg   <= {q_re_reg[QW-2:0], 1'b0};
                end
                if (rem_im_reg >= dsh_reg) begin
                    rem_im_reg <= rem_im_reg - dsh_reg;
                    q_im_reg   <= {q_im_reg[QW-2:0], 1'b1};
                end else begin
                    q_im_reg   <= {q_im_reg[QW-2:0], 1'b0};
                end
                dsh_reg <= dsh_reg >> 1;
            end
            default: ;
        endcase
    end

endmodule

// ===== hw/rtl/mgsd_controller.sv =====
// sweep sequencer, configuration registers and result register
`timescale 1ns / 1ps
module mgsd_controller #(
    parameter int MAX_TX = 4,
    parameter int MAX_RX = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [mgsd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [mgsd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                start,
    output logic                                idle,
    output mgsd_pkg::cmd_t                      cmd,
    input  mgsd_pkg::status_t                   status,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [1:0]                          m_idx,
    output logic [mgsd_pkg::EST_W-1:0]          m_re,
    output logic [mgsd_pkg::EST_W-1:0]          m_im,
    output logic                                m_last
);
    localparam int TX_LIM = (MAX_TX < mgsd_pkg::RESULT_LIMIT) ? MAX_TX
                                                               : mgsd_pkg::RESULT_LIMIT;

    mgsd_pkg::state_t state_reg, state_next;
    logic [2:0] act_tx_reg, act_rx_reg;
    logic [5:0] sweep_reg, s_reg, s_next;
    logic [4:0] i_reg, i_next, j_reg, j_next, k_reg, k_next, e_reg, e_next;
    logic [4:0] b_reg, b_next, ntx, nrx;
    logic       mv_reg, mv_next, ml_reg, ml_next;
    logic [1:0] mi_reg, mi_next;
    logic [mgsd_pkg::EST_W-1:0] mr_reg, mr_next, mm_reg, mm_next;

    // effective antenna counts
    always_comb begin
        if (act_tx_reg == 3'd0)           ntx = 5'd1;
        else if (int'(act_tx_reg) > TX_LIM) ntx = 5'(TX_LIM);
        else                              ntx = 5'(act_tx_reg);
        if (act_rx_reg == 3'd0)           nrx = 5'd1;
        else if (int'(act_rx_reg) > MAX_RX) nrx = 5'(MAX_RX);
        else                              nrx = 5'(act_rx_reg);
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_tx_reg <= 3'd4;
            act_rx_reg <= 3'd4;
            sweep_reg  <= 6'd10;
        end else if (cfg_we) begin
            case (cfg_addr)
                mgsd_pkg::REG_ACTIVE_TX:   act_tx_reg <= cfg_wdata[2:0];
                mgsd_pkg::REG_ACTIVE_RX:   act_rx_reg <= cfg_wdata[2:0];
                mgsd_pkg::REG_SWEEP_COUNT: sweep_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // state and counter registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mgsd_pkg::ST_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
        s_reg  <= s_next;
        i_reg  <= i_next;
        j_reg  <= j_next;
        k_reg  <= k_next;
        e_reg  <= e_next;
        b_reg  <= b_next;
        ml_reg <= ml_next;
        mi_reg <= mi_next;
        mr_reg <= mr_next;
        mm_reg <= mm_next;
    end

    // next state and commands
    always_comb begin
        state_next    = state_reg;
        s_next        = s_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        e_next        = e_reg;
        b_next        = b_reg;
        mv_next       = mv_reg && !m_tready;
        ml_next       = ml_reg;
        mi_next       = mi_reg;
        mr_next       = mr_reg;
        mm_next       = mm_reg;
        cmd.op        = mgsd_pkg::OP_NONE;
        cmd.row       = j_reg[3:0];
        cmd.col       = i_reg[3:0];
        cmd.self      = (k_reg == i_reg);
        cmd.first_row = (j_reg == 5'd0);
        idle          = 1'b0;
        case (state_reg)
            mgsd_pkg::ST_IDLE: begin
                idle = 1'b1;
                if (start) state_next = mgsd_pkg::ST_CLEAR;
            end
            mgsd_pkg::ST_CLEAR: begin
                cmd.op = mgsd_pkg::OP_CLEAR;
                s_next = '0;
                i_next = '0;
                j_next = '0;
                e_next = '0;
                state_next = (sweep_reg == '0) ? mgsd_pkg::ST_EMIT : mgsd_pkg::ST_ROW;
            end
            mgsd_pkg::ST_ROW: begin
                cmd.op = mgsd_pkg::OP_ROW;
                k_next = '0;
                state_next = mgsd_pkg::ST_RMUL;
            end
            mgsd_pkg::ST_RMUL: begin
                cmd.op  = mgsd_pkg::OP_RMUL;
                cmd.col = k_reg[3:0];
                state_next = mgsd_pkg::ST_RSUB;
            end
            mgsd_pkg::ST_RSUB: begin
                cmd.op = mgsd_pkg::OP_RSUB;
                if (k_reg == ntx - 5'd1) begin
                    state_next = mgsd_pkg::ST_NMUL;
                end else begin
                    k_next = k_reg + 5'd1;
                    state_next = mgsd_pkg::ST_RMUL;
                end
            end
            mgsd_pkg::ST_NMUL: begin
                cmd.op = mgsd_pkg::OP_NMUL;
                state_next = mgsd_pkg::ST_NACC;
            end
            mgsd_pkg::ST_NACC: begin
                cmd.op = mgsd_pkg::OP_NACC;
                if (j_reg == nrx - 5'd1) begin
                    j_next = '0;
                    state_next = mgsd_pkg::ST_DINIT;
                end else begin
                    j_next = j_reg + 5'd1;
                    state_next = mgsd_pkg::ST_ROW;
                end
            end
            mgsd_pkg::ST_DINIT: begin
                cmd.op = mgsd_pkg::OP_DINIT;
                b_next = 5'(mgsd_pkg::Q_BITS - 1);
                state_next = mgsd_pkg::ST_DSTEP;
            end
            mgsd_pkg::ST_DSTEP: begin
                cmd.op = mgsd_pkg::OP_DSTEP;
                if (b_reg == '0) state_next = mgsd_pkg::ST_DWRITE;
                else             b_next = b_reg - 5'd1;
            end
            mgsd_pkg::ST_DWRITE: begin
                cmd.op = mgsd_pkg::OP_DWRITE;
                state_next = mgsd_pkg::ST_ROW;
                if (i_reg == ntx - 5'd1) begin
                    i_next = '0;
                    if (s_reg == sweep_reg - 6'd1) begin
                        e_next = '0;
                        state_next = mgsd_pkg::ST_EMIT;
                    end else begin
                        s_next = s_reg + 6'd1;
                    end
                end else begin
                    i_next = i_reg + 5'd1;
                end
            end
            mgsd_pkg::ST_EMIT: begin
                cmd.col = e_reg[3:0];
                if (!mv_reg || m_tready) begin
                    mv_next = 1'b1;
                    mi_next = e_reg[1:0];
                    mr_next = status.est_re;
                    mm_next = status.est_im;
                    ml_next = (e_reg == ntx - 5'd1);
                    if (e_reg == ntx - 5'd1) state_next = mgsd_pkg::ST_IDLE;
                    else                     e_next = e_reg + 5'd1;
                end
            end
            default: state_next = mgsd_pkg::ST_IDLE;
        endcase
    end

    assign m_tvalid = mv_reg;
    assign m_idx    = mi_reg;
    assign m_re     = mr_reg;
    assign m_im     = mm_reg;
    assign m_last   = ml_reg;

endmodule

// ===== hw/rtl/mimo_gauss_seidel_detector.sv =====
// Gauss-Seidel MIMO detector: one request per cycle while idle.
// Coefficient and non-final sample requests only write the stores.
// A final sample starts detection: per sweep and transmitter the shared
// multiply-accumulate and serial divider form one estimate, then one result
// per active transmitter comes out. aresetn clears control state,
// estimates and configuration (4 tx, 4 rx, 10 sweeps); stores hold no reset.
`timescale 1ns / 1ps
`include "mimo_gauss_seidel_detector_assert.svh"
module mimo_gauss_seidel_detector #(
    parameter int MAX_TX = 4,
    parameter int MAX_RX = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [5:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // rx_index, tx_index_in, value_re, value_im, zero pad
    input  logic        s_tuser,   // mode
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // tx_index, estimate_re, estimate_im, zero pad
    output logic        m_tlast
);
    mgsd_pkg::load_t   load;
    mgsd_pkg::cmd_t    cmd;
    mgsd_pkg::status_t status;
    logic        idle, start, s_acc;
    logic [1:0]  m_idx;
    logic [17:0] m_re, m_im;

    // input request decode
    assign s_tready  = idle;
    assign s_acc     = s_tvalid && s_tready;
    assign start     = s_acc && s_tuser && s_tlast;
    assign load.we   = s_acc;
    assign load.mode = s_tuser;
    assign load.rx   = s_tdata[1:0];
    assign load.tx   = s_tdata[3:2];
    assign load.re   = s_tdata[19:4];
    assign load.im   = s_tdata[35:20];

    mgsd_controller #(.MAX_TX(MAX_TX), .MAX_RX(MAX_RX)) u_ctl (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .start(start), .idle(idle), .cmd(cmd), .status(status),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_idx(m_idx), .m_re(m_re), .m_im(m_im), .m_last(m_tlast)
    );

    mgsd_datapath #(.MAX_TX(MAX_TX), .MAX_RX(MAX_RX)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .load(load), .cmd(cmd), .status(status)
    );

    assign m_tdata = {2'b00, m_im, m_re, m_idx};

    // a started slot makes the block busy
    `MGSD_ASSERT_NEXT(a_start_busy, aclk, aresetn, start, !s_tready)
    // a stalled result stays valid
    `MGSD_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    // a stalled result keeps its data
    `MGSD_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))

endmodule

// ===== bench/mimo_gauss_seidel_detector_checker.sv =====
// channel monitor, estimate predictor and result checker for the detector
`timescale 1ns / 1ps
module mimo_gauss_seidel_detector_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [5:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // rx_index, tx_index_in, value_re, value_im, zero pad
    input  logic        s_tuser,   // mode
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // tx_index, estimate_re, estimate_im, zero pad
    input  logic        m_tlast,
    output int          errors,
    output int          pending,
    output int          results_seen
);
    typedef struct {
        logic [1:0]                        tx;
        logic signed [mgsd_pkg::EST_W-1:0] re;
        logic signed [mgsd_pkg::EST_W-1:0] im;
        logic                              last;
    } estimate_t;

    // model state: channel matrix, samples, estimates and settings
    longint    chan_re [4][4];
    longint    chan_im [4][4];
    longint    rx_re   [4];
    longint    rx_im   [4];
    longint    mu_re   [4];
    longint    mu_im   [4];
    logic [2:0] n_tx_reg;
    logic [2:0] n_rx_reg;
    logic [5:0] n_sweeps;
    estimate_t estimate_q [$];

    function automatic longint sat_est(longint v);
        if (v > 131071) return 131071;
        if (v < -131072) return -131072;
        return v;
    endfunction

    // nearest, ties away from zero
    function automatic longint round_quot(longint num, longint den);
        longint mag, q;
        mag = num < 0 ? -num : num;
        q = (2 * mag + den) / (2 * den);
        return num < 0 ? -q : q;
    endfunction

    // in-place gauss-seidel sweeps over the active antennas
    task automatic solve_slot(int ntx, int nrx);
        longint num_re, num_im, pwr, hr, hi, rr, ri;
        for (int i = 0; i < 4; i++) begin
            mu_re[i] = 0;
            mu_im[i] = 0;
        end
        for (int s = 0; s < n_sweeps; s++) begin
            for (int i = 0; i < ntx; i++) begin
                num_re = 0; num_im = 0; pwr = 0;
                for (int j = 0; j < nrx; j++) begin
                    hr = chan_re[j][i];
                    hi = chan_im[j][i];
                    rr = rx_re[j] * 4096;
                    ri = rx_im[j] * 4096;
                    for (int k = 0; k < ntx; k++) begin
                        if (k != i) begin
                            rr -= chan_re[j][k] * mu_re[k] - chan_im[j][k] * mu_im[k];
                            ri -= chan_re[j][k] * mu_im[k] + chan_im[j][k] * mu_re[k];
                        end
                    end
                    num_re += hr * rr + hi * ri;
                    num_im += hr * ri - hi * rr;
                    pwr += hr * hr + hi * hi;
                end
                // zero column power leaves the estimate alone
                if (pwr > 0) begin
                    mu_re[i] = sat_est(round_quot(num_re, pwr));
                    mu_im[i] = sat_est(round_quot(num_im, pwr));
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        int         ntx, nrx;
        logic [1:0] rx, tx;
        estimate_t  e, got;
        if (!aresetn) begin
            n_tx_reg = 3'd4;
            n_rx_reg = 3'd4;
            n_sweeps = 6'd10;
            errors = 0;
            results_seen = 0;
            estimate_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    mgsd_pkg::REG_ACTIVE_TX:   n_tx_reg = cfg_wdata[2:0];
                    mgsd_pkg::REG_ACTIVE_RX:   n_rx_reg = cfg_wdata[2:0];
                    mgsd_pkg::REG_SWEEP_COUNT: n_sweeps = cfg_wdata;
                    default: ;
                endcase
            end
            // input request: store load, maybe a detection
            if (s_tvalid && s_tready) begin
                rx = s_tdata[1:0];
                tx = s_tdata[3:2];
                if (!s_tuser) begin
                    chan_re[rx][tx] = longint'($signed(s_tdata[19:4]));
                    chan_im[rx][tx] = longint'($signed(s_tdata[35:20]));
                end else begin
                    rx_re[rx] = longint'($signed(s_tdata[19:4]));
                    rx_im[rx] = longint'($signed(s_tdata[35:20]));
                    if (s_tlast) begin
                        ntx = n_tx_reg == 0 ? 1 : (n_tx_reg > 4 ? 4 : int'(n_tx_reg));
                        nrx = n_rx_reg == 0 ? 1 : (n_rx_reg > 4 ? 4 : int'(n_rx_reg));
                        solve_slot(ntx, nrx);
                        for (int i = 0; i < ntx; i++) begin
                            e.tx = i[1:0];
                            e.re = mu_re[i][17:0];
                            e.im = mu_im[i][17:0];
                            e.last = (i == ntx - 1);
                            estimate_q.push_back(e);
                        end
                    end
                end
            end
            // result request: compare with the oldest estimate
            if (m_tvalid && m_tready) begin
                got.tx = m_tdata[1:0];
                got.re = m_tdata[19:2];
                got.im = m_tdata[37:20];
                got.last = m_tlast;
                results_seen++;
                if (estimate_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result tx %0d re %0d im %0d last %0b",
                             $time, got.tx, got.re, got.im, got.last);
                end else begin
                    e = estimate_q.pop_front();
                    if (got.tx !== e.tx || got.re !== e.re || got.im !== e.im
                            || got.last !== e.last) begin
                        errors++;
                        $display("%0t: mismatch expected tx %0d re %0d im %0d last %0b",
                                 $time, e.tx, e.re, e.im, e.last);
                        $display("%0t:          actual   tx %0d re %0d im %0d last %0b",
                                 $time, got.tx, got.re, got.im, got.last);
                    end
                end
            end
        end
        pending = estimate_q.size();
    end

endmodule

// ===== bench/mimo_gauss_seidel_detector_tb.sv =====
// top of the detector testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module mimo_gauss_seidel_detector_tb;

    localparam int SETTLE = 40;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [5:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // rx_index, tx_index_in, value_re, value_im, zero pad
    logic        s_tuser;   // mode
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // tx_index, estimate_re, estimate_im, zero pad
    logic        m_tlast;

    int errors, pending, results_seen;
    int send_idle_pct, recv_idle_pct;
    int hold_cycles;
    int items_sent, slots_sent;

    mimo_gauss_seidel_detector uut (.*);

    mimo_gauss_seidel_detector_checker chk (
        .aclk, .aresetn, .cfg_we, .cfg_addr, .cfg_wdata,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
        .m_tvalid, .m_tready, .m_tdata, .m_tlast,
        .errors, .pending, .results_seen
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // receiver: random stalls, or a long hold-off when asked
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // one input request, with random gaps before it
    task automatic send_item(logic mode, logic [1:0] rx, logic [1:0] tx,
                             logic [15:0] re, logic [15:0] im, logic slot_end);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tlast  <= slot_end;
        s_tdata  <= {4'b0, im, re, tx, rx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if (mode && slot_end) slots_sent++;
    endtask

    // wait for the block to drain, then write one register
    task automatic write_reg(logic [1:0] idx, logic [5:0] val);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        repeat (SETTLE) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] rand_value();
        case ($urandom_range(3))
            0: return ($urandom_range(1) ? 16'h7FFF : 16'h8000);
            1: return 16'($signed($urandom_range(8192)) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    // a slot: a few coefficient updates then the received samples
    task automatic send_slot();
        int n_load, n_smp;
        n_load = $urandom_range(4);
        n_smp  = $urandom_range(1, 4);
        for (int i = 0; i < n_load; i++)
            send_item(1'b0, 2'($urandom), 2'($urandom), rand_value(), rand_value(),
                      1'b0);
        // occasional noise: a flagged coefficient, whose flag must be ignored
        if ($urandom_range(9) == 0)
            send_item(1'b0, 2'($urandom), 2'($urandom), rand_value(), rand_value(),
                      1'b1);
        for (int i = 0; i < n_smp; i++)
            send_item(1'b1, 2'($urandom), 2'($urandom), rand_value(), rand_value(),
                      i == n_smp - 1);
    endtask

    task automatic set_idling();
        if (items_sent < 130) begin
            send_idle_pct = 27; recv_idle_pct = 63;
        end else if (items_sent < 240) begin
            send_idle_pct = 63; recv_idle_pct = 27;
        end else begin
            send_idle_pct = 0;  recv_idle_pct = 0;
        end
    endtask

    task automatic config_all(logic [5:0] ntx, logic [5:0] nrx, logic [5:0] sweeps);
        write_reg(mgsd_pkg::REG_ACTIVE_TX, ntx);
        write_reg(mgsd_pkg::REG_ACTIVE_RX, nrx);
        write_reg(mgsd_pkg::REG_SWEEP_COUNT, sweeps);
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_we <= 1'b0; cfg_addr <= '0; cfg_wdata <= '0;
        s_tvalid <= 1'b0; s_tdata <= '0; s_tuser <= 1'b0; s_tlast <= 1'b0;
        hold_cycles = 0;
        items_sent = 0; slots_sent = 0;
        send_idle_pct = 0; recv_idle_pct = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: full matrix with extremes, column three left at zero power
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                send_item(1'b0, r[1:0], c[1:0],
                          c == 3 ? 16'h0 : (((r + c) % 2) ? 16'h7FFF : 16'h8000),
                          c == 3 ? 16'h0 : (r == c ? 16'h1000 : 16'hF000), 1'b0);
        send_item(1'b0, 2'd2, 2'd1, 16'h8000, 16'h7FFF, 1'b1);
        send_item(1'b1, 2'd0, 2'd0, 16'h7FFF, 16'h8000, 1'b0);
        send_item(1'b1, 2'd1, 2'd3, 16'h8000, 16'h7FFF, 1'b0);
        send_item(1'b1, 2'd2, 2'd0, 16'h0000, 16'hFFFF, 1'b0);
        send_item(1'b1, 2'd3, 2'd1, 16'h0001, 16'h0000, 1'b1);

        // random slots over several settings, extremes among them
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: config_all(6'd4, 6'd4, 6'd10);
                1: config_all(6'd1, 6'd1, 6'd1);
                2: config_all(6'd0, 6'd7, 6'd63);
                3: config_all(6'd3, 6'd2, 6'd0);
                4: config_all(6'd7, 6'd0, 6'd32);
                default: config_all(6'd2, 6'd3, 6'd4);
            endcase
            for (int s = 0; s < (p == 2 || p == 4 ? 3 : 14); s++) begin
                set_idling();
                send_slot();
                if (p == 1 && s == 4) begin
                    // long receiver hold-off while requests keep coming
                    hold_cycles = 600;
                    for (int k = 0; k < 3; k++) send_slot();
                end
                if (p == 5 && s == 6) begin
                    // sender pause until every estimate has come out
                    s_tvalid <= 1'b0;
                    @(posedge aclk);
                    wait (pending == 0);
                end
            end
        end
        while (items_sent < 320) begin
            set_idling();
            send_slot();
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        wait (pending == 0);
        repeat (SETTLE) @(posedge aclk);
        $display("covered %0d requests, %0d slots, %0d estimates checked",
                 items_sent, slots_sent, results_seen);
        $display("settings swept: 0 to 7 antennas each side, 0 to 63 sweeps");
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #15_000_000;
        $display("timeout");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
